>>> design/lbps_pkg.sv
package lbps_pkg;

   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned KIND_W      = 3;
   localparam int unsigned CSR_DATA_W  = 5;
   localparam int unsigned CSR_INDEX_W = 4;

   // most results one tick may produce
   localparam logic [CSR_DATA_W-1:0] MAX_RESULTS = 5'd16;

   localparam logic [CMD_W-1:0] CMD_OFFER  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PACKET = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ENQUEUED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SENT     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_IDLE     = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_LIMIT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAIN_RATE = 4'd1;

   localparam logic [CSR_DATA_W-1:0] SLOT_LIMIT_RESET = 5'd16;
   localparam logic [CSR_DATA_W-1:0] DRAIN_RATE_RESET = 5'd1;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] slot_limit;
      logic [CSR_DATA_W-1:0] drain_rate;
   } cfg_type;

endpackage

>>> design/lbps_if.sv
interface lbps_req_if;
   import lbps_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic [COUNT_W-1:0]        packet_count;
   logic signed [VALUE_W-1:0] packet_value;

   modport source (output valid, command, packet_count, packet_value, input ready);
   modport sink   (input valid, command, packet_count, packet_value, output ready);
endinterface

interface lbps_rsp_if;
   import lbps_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [VALUE_W-1:0] packet_value_res;
   logic                      last;

   modport source (output valid, kind, packet_value_res, last, input ready);
   modport sink   (input valid, kind, packet_value_res, last, output ready);
endinterface

interface lbps_csr_if;
   import lbps_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/leaky_bucket_packet_shaper.sv
// Channel   Dir  Contents
// req_chan  in   command, packet_count, packet_value
// rsp_chan  out  kind, packet_value_res, last
// csr_chan  in   index, data (0 slot_limit, 1 drain_rate)
//
// Offer and packet items each produce one result, which sits in the output register.
// A draining tick first issues the read of the first packet from the packet store,
// then sends one transfer per cycle unless rsp_chan stalls, with the next read
// overlapped (one RAM read port). Unused command code 3 is taken and produces nothing.
// Reset is synchronous and empties the FIFO; store contents need no clearing.
// A stalled rsp_chan holds the pending result and the drain; req_chan waits.
module leaky_bucket_packet_shaper #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   lbps_req_if.sink   req_chan,
   lbps_rsp_if.source rsp_chan,
   lbps_csr_if.sink   csr_chan
);
   import lbps_pkg::*;

   localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);

   logic [CSR_DATA_W-1:0] slot_limit_ff;
   logic [CSR_DATA_W-1:0] drain_rate_ff;
   cfg_type               cfg;

   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0]    ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0]    ram_rd_data;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_limit_ff <= SLOT_LIMIT_RESET;
         drain_rate_ff <= DRAIN_RATE_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SLOT_LIMIT: slot_limit_ff <= csr_chan.data;
            CSR_DRAIN_RATE: drain_rate_ff <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.slot_limit = slot_limit_ff;
   assign cfg.drain_rate = drain_rate_ff;

   lbps_ctrl #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   lbps_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

>>> design/lbps_ram.sv
module lbps_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lbps_ctrl.sv
module lbps_ctrl #(
   parameter int unsigned FIFO_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lbps_pkg::cfg_type                   cfg,
   lbps_req_if.sink                            req,
   lbps_rsp_if.source                          rsp,
   output logic                                ram_wr_en,
   output logic [$clog2(FIFO_DEPTH)-1:0]       ram_wr_addr,
   output logic [lbps_pkg::VALUE_W-1:0]        ram_wr_data,
   output logic                                ram_rd_en,
   output logic [$clog2(FIFO_DEPTH)-1:0]       ram_rd_addr,
   input  logic [lbps_pkg::VALUE_W-1:0]        ram_rd_data
);
   import lbps_pkg::*;

   localparam int unsigned IDX_W = $clog2(FIFO_DEPTH);
   localparam int unsigned OCC_W = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned CW    = (OCC_W > CSR_DATA_W) ? OCC_W : CSR_DATA_W;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FIFO_DEPTH - 1);
   localparam logic [CW-1:0]    DEPTH_CW  = CW'(FIFO_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [CW-1:0]      remain_ff, remain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;

   logic               out_free;
   logic               req_fire;
   logic [CW-1:0]      occ_cw;
   logic [CW-1:0]      limit;
   logic [CW-1:0]      free_slots;
   logic [CW-1:0]      budget;
   logic [CW-1:0]      drain_n;
   logic [IDX_W-1:0]   head_next;
   logic [IDX_W-1:0]   tail_next;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req.valid && req.ready;

   assign occ_cw     = CW'(occ_ff);
   assign limit      = (CW'(cfg.slot_limit) > DEPTH_CW) ? DEPTH_CW : CW'(cfg.slot_limit);
   assign free_slots = (occ_cw >= limit) ? '0 : limit - occ_cw;
   assign budget     = (cfg.drain_rate > MAX_RESULTS) ? CW'(MAX_RESULTS)
                                                      : CW'(cfg.drain_rate);
   assign drain_n    = (budget < occ_cw) ? budget : occ_cw;

   assign head_next = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;

   assign ram_wr_addr = tail_ff;
   assign ram_wr_data = req.packet_value;
   assign ram_rd_addr = head_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req.command)
                  CMD_OFFER: begin
                     rsp_valid_in = 1'b1;
                     kind_in      = (CW'(req.packet_count) <= free_slots) ? KIND_ACCEPTED
                                                                          : KIND_REJECTED;
                     value_in     = '0;
                     last_in      = 1'b1;
                  end
                  CMD_PACKET: begin
                     rsp_valid_in = 1'b1;
                     value_in     = '0;
                     last_in      = 1'b1;
                     if (free_slots == '0) begin
                        kind_in = KIND_DROPPED;
                     end else begin
                        kind_in   = KIND_ENQUEUED;
                        ram_wr_en = 1'b1;
                        tail_in   = tail_next;
                        occ_in    = occ_ff + 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     if (drain_n == '0) begin
                        rsp_valid_in = 1'b1;
                        kind_in      = KIND_IDLE;
                        value_in     = '0;
                        last_in      = 1'b1;
                     end else begin
                        // first read goes out now, data lands for ST_SEND
                        ram_rd_en = 1'b1;
                        head_in   = head_next;
                        occ_in    = occ_ff - 1'b1;
                        remain_in = drain_n - 1'b1;
                        state_in  = ST_SEND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_SENT;
               value_in     = ram_rd_data;
               last_in      = (remain_ff == '0);
               if (remain_ff != '0) begin
                  // next read overlaps this transfer; read data holds while stalled
                  ram_rd_en = 1'b1;
                  head_in   = head_next;
                  occ_in    = occ_ff - 1'b1;
                  remain_in = remain_ff - 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.kind             = kind_ff;
   assign rsp.packet_value_res = value_ff;
   assign rsp.last             = last_ff;

endmodule

>>> verif/tb_leaky_bucket_packet_shaper.sv
`timescale 1ns / 100ps

module tb_leaky_bucket_packet_shaper;
   import lbps_pkg::*;

   localparam int unsigned DEPTH              = 16;
   localparam int unsigned CYCLE_LIMIT        = 400000;
   // longest tick drains 16 packets; idle time before a CSR write
   localparam int unsigned SETTLE_CYCLES      = 24;
   localparam int unsigned RANDOM_PHASES      = 8;
   localparam int unsigned RANDOM_PHASE_ITEMS = 32;

   localparam logic [CMD_W-1:0]       CMD_UNUSED   = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 4'hF;

   typedef struct {
      logic [CMD_W-1:0]          command;
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] value;
   } shaper_item_type;

   typedef struct {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } shaper_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lbps_req_if req_chan();
   lbps_rsp_if rsp_chan();
   lbps_csr_if csr_chan();

   leaky_bucket_packet_shaper #(.FIFO_DEPTH(DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // bucket state as the shaper should hold it
   logic signed [VALUE_W-1:0] bucket_store [DEPTH];
   int unsigned               bucket_head;
   int unsigned               bucket_tail;
   int unsigned               bucket_fill;
   cfg_type                   shaper_cfg;

   shaper_item_type   pending_items [$];
   shaper_result_type awaited_results [$];
   shaper_item_type   taken_item;
   shaper_item_type   next_item;
   shaper_result_type oldest_result;

   int unsigned error_count;
   int unsigned items_taken;
   int unsigned results_seen;
   int unsigned settings_used;
   int unsigned cycle_count;
   int unsigned kind_seen [8];

   bit          req_taken;
   int unsigned burst_left = 1;
   int unsigned gap_left;
   int unsigned pattern_left;
   logic [15:0] stall_pattern = '1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic expect_result(input logic [KIND_W-1:0] kind,
                                input logic signed [VALUE_W-1:0] value,
                                input logic last);
      shaper_result_type r;
      r.kind  = kind;
      r.value = value;
      r.last  = last;
      awaited_results.push_back(r);
   endtask

   task automatic predict_results(input shaper_item_type item);
      int unsigned cap, room, budget, n, k;
      cap  = (shaper_cfg.slot_limit > DEPTH) ? DEPTH : shaper_cfg.slot_limit;
      room = (bucket_fill >= cap) ? 0 : cap - bucket_fill;
      case (item.command)
         CMD_OFFER: begin
            if (item.count <= room) expect_result(KIND_ACCEPTED, '0, 1'b1);
            else expect_result(KIND_REJECTED, '0, 1'b1);
         end
         CMD_PACKET: begin
            if (room == 0) begin
               expect_result(KIND_DROPPED, '0, 1'b1);
            end else begin
               bucket_store[bucket_tail] = item.value;
               bucket_tail = (bucket_tail + 1 == DEPTH) ? 0 : bucket_tail + 1;
               bucket_fill++;
               expect_result(KIND_ENQUEUED, '0, 1'b1);
            end
         end
         CMD_TICK: begin
            budget = (shaper_cfg.drain_rate > MAX_RESULTS) ? MAX_RESULTS
                                                           : shaper_cfg.drain_rate;
            n = (budget < bucket_fill) ? budget : bucket_fill;
            if (n == 0) expect_result(KIND_IDLE, '0, 1'b1);
            for (k = 0; k < n; k++) begin
               expect_result(KIND_SENT, bucket_store[bucket_head], k + 1 == n);
               bucket_head = (bucket_head + 1 == DEPTH) ? 0 : bucket_head + 1;
               bucket_fill--;
            end
         end
         default: ;
      endcase
   endtask

   // sampling at the rising edge: transfers, predictions and result checks
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_chan.valid && req_chan.ready;
         if (req_taken) begin
            taken_item.command = req_chan.command;
            taken_item.count   = req_chan.packet_count;
            taken_item.value   = req_chan.packet_value;
            items_taken++;
            predict_results(taken_item);
         end
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_SLOT_LIMIT: shaper_cfg.slot_limit = csr_chan.data;
               CSR_DRAIN_RATE: shaper_cfg.drain_rate = csr_chan.data;
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            kind_seen[rsp_chan.kind]++;
            if (awaited_results.size() == 0) begin
               error_count++;
               $error("unexpected result: kind %0d value %0d last %0d",
                      rsp_chan.kind, rsp_chan.packet_value_res, rsp_chan.last);
            end else begin
               oldest_result = awaited_results.pop_front();
               if (rsp_chan.kind !== oldest_result.kind) begin
                  error_count++;
                  $error("kind: expected %0d, got %0d", oldest_result.kind, rsp_chan.kind);
               end
               if (rsp_chan.packet_value_res !== oldest_result.value) begin
                  error_count++;
                  $error("packet_value_res: expected %0d, got %0d",
                         oldest_result.value, rsp_chan.packet_value_res);
               end
               if (rsp_chan.last !== oldest_result.last) begin
                  error_count++;
                  $error("last: expected %0d, got %0d", oldest_result.last, rsp_chan.last);
               end
            end
         end
      end
   end

   // sender: bursts of random length, random gaps between them
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            next_item = pending_items.pop_front();
            req_chan.valid        <= 1'b1;
            req_chan.command      <= next_item.command;
            req_chan.packet_count <= next_item.count;
            req_chan.packet_value <= next_item.value;
            if (burst_left > 1) begin
               burst_left--;
            end else if ($urandom_range(0, 3) == 0) begin
               burst_left = $urandom_range(20, 60);
               gap_left   = 0;
            end else begin
               burst_left = $urandom_range(1, 8);
               gap_left   = $urandom_range(1, 5);
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver: rotating stall pattern, reloaded now and then
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         case ($urandom_range(0, 2))
            0: stall_pattern = '1;
            1: stall_pattern = 16'($urandom) | 16'h1;
            default: stall_pattern = 16'($urandom & $urandom) | 16'h1;
         endcase
         pattern_left = $urandom_range(8, 64);
      end else begin
         pattern_left--;
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      rsp_chan.ready <= stall_pattern[0];
   end

   task automatic queue_item(input logic [CMD_W-1:0] command,
                             input logic [COUNT_W-1:0] count,
                             input logic signed [VALUE_W-1:0] value);
      shaper_item_type item;
      item.command = command;
      item.count   = count;
      item.value   = value;
      pending_items.push_back(item);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] slots,
                            input logic [CSR_DATA_W-1:0] rate);
      write_register(CSR_SLOT_LIMIT, slots);
      write_register(CSR_DRAIN_RATE, rate);
      @(negedge clock) csr_chan.valid <= 1'b0;
      settings_used++;
   endtask

   // hold off until every item is taken and every result is back;
   // checked at the rising edge, where the sender's outputs have settled
   task automatic wait_quiet();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_chan.valid || awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_random_items(input int unsigned n);
      int unsigned i, pick, fill_share;
      logic signed [VALUE_W-1:0] word;
      // some phases lean toward filling, others toward draining
      fill_share = $urandom_range(25, 65);
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         word = $urandom;
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0: word = 32'h8000_0000;
               1: word = 32'h7FFF_FFFF;
               2: word = '0;
               default: word = '1;
            endcase
         end
         if (pick < 4)
            queue_item(CMD_UNUSED, COUNT_W'($urandom), word);
         else if (pick < 4 + fill_share)
            queue_item(CMD_PACKET, COUNT_W'($urandom), word);
         else if (pick < 4 + fill_share + (96 - fill_share) / 2)
            queue_item(CMD_TICK, COUNT_W'($urandom), word);
         else if ($urandom_range(0, 1) == 0)
            queue_item(CMD_OFFER, COUNT_W'($urandom_range(0, 17)), word);
         else
            queue_item(CMD_OFFER, COUNT_W'($urandom), word);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] phase_slots [6];
      logic [CSR_DATA_W-1:0] phase_rates [6];
      logic [CSR_DATA_W-1:0] slots, rate;
      int unsigned p;

      phase_slots = '{5'd31, 5'd16, 5'd1, 5'd4, 5'd0, 5'd12};
      phase_rates = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd5};

      req_chan.valid        = 1'b0;
      req_chan.command      = CMD_OFFER;
      req_chan.packet_count = '0;
      req_chan.packet_value = '0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = CSR_SLOT_LIMIT;
      csr_chan.data         = '0;
      shaper_cfg.slot_limit = SLOT_LIMIT_RESET;
      shaper_cfg.drain_rate = DRAIN_RATE_RESET;
      bucket_head = 0;
      bucket_tail = 0;
      bucket_fill = 0;

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // reset settings: empty tick, offer bounds, unused code, payload extremes
      queue_item(CMD_TICK, '0, '0);
      queue_item(CMD_OFFER, 5'd0, '0);
      queue_item(CMD_OFFER, 5'd16, '0);
      queue_item(CMD_OFFER, 5'd17, '0);
      queue_item(CMD_OFFER, 5'd31, '1);
      queue_item(CMD_UNUSED, 5'd31, '1);
      queue_item(CMD_PACKET, '1, 32'h8000_0000);
      queue_item(CMD_PACKET, '0, 32'h7FFF_FFFF);
      queue_item(CMD_PACKET, '0, '0);
      queue_item(CMD_PACKET, '0, '1);
      queue_item(CMD_TICK, '0, '0);
      wait_quiet();

      // capacity below occupancy, drain rate above the per-tick maximum
      configure(5'd2, 5'd31);
      queue_item(CMD_PACKET, '0, 32'h1234_5678);
      queue_item(CMD_OFFER, 5'd0, '0);
      queue_item(CMD_OFFER, 5'd1, '0);
      queue_item(CMD_TICK, '0, '0);
      queue_item(CMD_TICK, '0, '0);
      wait_quiet();

      // zero capacity and zero drain rate; unmapped index must be ignored
      write_register(CSR_UNMAPPED, 5'd31);
      configure(5'd0, 5'd0);
      queue_item(CMD_PACKET, '0, 32'h5A5A_A5A5);
      queue_item(CMD_OFFER, 5'd0, '0);
      queue_item(CMD_OFFER, 5'd1, '0);
      queue_item(CMD_TICK, '0, '0);
      wait_quiet();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 6) begin
            slots = phase_slots[p];
            rate  = phase_rates[p];
         end else begin
            slots = CSR_DATA_W'($urandom);
            rate  = CSR_DATA_W'($urandom);
         end
         configure(slots, rate);
         queue_random_items(RANDOM_PHASE_ITEMS);
         wait_quiet();
      end

      if (awaited_results.size() != 0) begin
         error_count++;
         $error("results outstanding: expected 0, got %0d", awaited_results.size());
      end

      $display("covered %0d items and %0d results over %0d register settings",
               items_taken, results_seen, settings_used);
      $display("accepted %0d rejected %0d enqueued %0d dropped %0d sent %0d idle %0d",
               kind_seen[KIND_ACCEPTED], kind_seen[KIND_REJECTED],
               kind_seen[KIND_ENQUEUED], kind_seen[KIND_DROPPED],
               kind_seen[KIND_SENT], kind_seen[KIND_IDLE]);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
design/lbps_pkg.sv
design/lbps_if.sv
design/lbps_ram.sv
design/lbps_ctrl.sv
design/leaky_bucket_packet_shaper.sv
verif/tb_leaky_bucket_packet_shaper.sv
